// ===== design/codepoint_to_byte_table_translator_defines.svh =====
// assertion macros used by the top-level design file
`ifndef CODEPOINT_TO_BYTE_TABLE_TRANSLATOR_DEFINES_SVH
`define CODEPOINT_TO_BYTE_TABLE_TRANSLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CTBT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ctbt assertion failed");
`define CTBT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ctbt assertion failed");
`else
`define CTBT_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CTBT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/ctbt_pkg.sv =====
package ctbt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 512;
    localparam int RESET_ENTRIES       = 128;
    localparam int CODE_W              = 16;
    localparam int BYTE_W              = 8;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_LOAD      = 2'd1,
        OP_CLEAR     = 2'd2
    } op_t;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    // request walking down the row, one cell per cycle
    typedef struct packed {
        logic              active;
        op_t               op;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] mbyte;
        logic              full;
        logic              done;
        logic              hit;
        logic [BYTE_W-1:0] hit_byte;
        logic              reject;
        logic              carry_valid;
        logic [CODE_W-1:0] carry_code;
        logic [BYTE_W-1:0] carry_byte;
    } tok_t;

endpackage

// ===== design/codepoint_to_byte_table_translator.sv =====
// a result passes from the last cell register through a pending register to the output register on m_tvalid
// one request at a time walks the row of TABLE_DEPTH cells, one cell per cycle
// no new request is taken until the last leaves the row and any result reaches the output register
// a finished result waits in the output register while the next request is taken
// reset: synchronous active low aresetn, table holds identity pairs for codes 0 to 127
`include "codepoint_to_byte_table_translator_defines.svh"

module codepoint_to_byte_table_translator
    import ctbt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // code[15:0], mapped_byte[23:16]
    input  logic [1:0]  s_tuser,  // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // out_byte[7:0]
    output logic        m_tuser   // kind[0]
);

    tok_t                   tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] tok_act;
    tok_t                   exit_tok;
    logic                   exit_reject;

    logic              busy_reg;
    logic              pend_reg;
    logic              pend_kind_reg;
    logic [BYTE_W-1:0] pend_byte_reg;
    logic              m_tvalid_reg;
    logic              m_tuser_reg;
    logic [BYTE_W-1:0] m_tdata_reg;
    logic              s_accept;
    logic              out_free;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && !busy_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        tok[0]             = '0;
        tok[0].active      = s_accept;
        tok[0].op          = op_t'(s_tuser);
        tok[0].code        = s_tdata[CODE_W-1:0];
        tok[0].mbyte       = s_tdata[CODE_W+BYTE_W-1:CODE_W];
        tok[0].full        = cell_valid[TABLE_DEPTH-1];
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ctbt_cell #(
            .IS_HEAD    (i == 0),
            .INIT_VALID (i < RESET_ENTRIES),
            .INIT_CODE  ((i < RESET_ENTRIES) ? CODE_W'(i) : '0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1]),
            .valid_out (cell_valid[i])
        );
        assign tok_act[i] = tok[i+1].active;
    end

    assign exit_tok = tok[TABLE_DEPTH];

    // a cell rejected the load, or full table with new code above every entry: no cell took the load
    assign exit_reject = exit_tok.reject ||
                         (exit_tok.op == OP_LOAD && exit_tok.full && !exit_tok.done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                busy_reg <= 1'b1;
            end
            if (exit_tok.active) begin
                if (exit_tok.hit || exit_reject) begin
                    pend_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                end
            end
            if (pend_reg && out_free) begin
                m_tvalid_reg <= 1'b1;
                pend_reg     <= 1'b0;
                busy_reg     <= 1'b0;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exit_tok.active) begin
            pend_kind_reg <= exit_reject ? KIND_REJECT : KIND_BYTE;
            pend_byte_reg <= exit_reject ? '0 : exit_tok.hit_byte;
        end
        if (pend_reg && out_free) begin
            m_tuser_reg <= pend_kind_reg;
            m_tdata_reg <= pend_byte_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    `CTBT_ASSERT_IMPL(a_one_request_in_row, aclk, aresetn, 1'b1, $onehot0(tok_act))
    `CTBT_ASSERT_IMPL(a_row_busy, aclk, aresetn, $countones(tok_act) != 0, busy_reg)
    `CTBT_ASSERT_IMPL(a_pend_busy, aclk, aresetn, pend_reg, busy_reg)
    `CTBT_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, tok_act[0])

endmodule

// ===== design/ctbt_cell.sv =====
module ctbt_cell
    import ctbt_pkg::*;
#(
    parameter bit              IS_HEAD    = 1'b0,
    parameter bit              INIT_VALID = 1'b0,
    parameter logic [CODE_W-1:0] INIT_CODE = '0
) (
    input  logic aclk,
    input  logic aresetn,
    input  tok_t tok_in,
    output tok_t tok_out,
    output logic valid_out
);

    logic              valid_reg, valid_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    tok_t              tok_reg, tok_next;

    always_comb begin
        valid_next = valid_reg;
        code_next  = code_reg;
        byte_next  = byte_reg;
        tok_next   = tok_in;
        if (tok_in.active) begin
            unique case (tok_in.op)
                OP_TRANSLATE: begin
                    if (!tok_in.done && valid_reg) begin
                        if (code_reg == tok_in.code) begin
                            tok_next.hit      = 1'b1;
                            tok_next.hit_byte = byte_reg;
                            tok_next.done     = 1'b1;
                        end else if (code_reg > tok_in.code) begin
                            tok_next.done = 1'b1;
                        end
                    end
                end
                OP_LOAD: begin
                    if (tok_in.carry_valid) begin
                        // shifting entries up by one place
                        valid_next           = 1'b1;
                        code_next            = tok_in.carry_code;
                        byte_next            = tok_in.carry_byte;
                        tok_next.carry_valid = valid_reg;
                        tok_next.carry_code  = code_reg;
                        tok_next.carry_byte  = byte_reg;
                    end else if (!tok_in.done) begin
                        if (valid_reg && code_reg == tok_in.code) begin
                            byte_next     = tok_in.mbyte;
                            tok_next.done = 1'b1;
                        end else if (!valid_reg || code_reg > tok_in.code) begin
                            tok_next.done = 1'b1;
                            if (tok_in.full) begin
                                tok_next.reject = 1'b1;
                            end else begin
                                valid_next           = 1'b1;
                                code_next            = tok_in.code;
                                byte_next            = tok_in.mbyte;
                                tok_next.carry_valid = valid_reg;
                                tok_next.carry_code  = code_reg;
                                tok_next.carry_byte  = byte_reg;
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    valid_next = IS_HEAD;
                    code_next  = '0;
                    byte_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= INIT_VALID;
            code_reg  <= INIT_CODE;
            byte_reg  <= INIT_CODE[BYTE_W-1:0];
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            code_reg  <= code_next;
            byte_reg  <= byte_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out   = tok_reg;
    assign valid_out = valid_reg;

endmodule

// ===== bench/codepoint_to_byte_table_translator_tb.sv =====
`timescale 1ns / 100ps

module codepoint_to_byte_table_translator_tb;
    import ctbt_pkg::*;

    localparam int          DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int          CYCLE_LIMIT = 8_000_000;
    localparam int          ITEM_TARGET = 750;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } lookup_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] code;
        logic [7:0]  mb;
    } request_t;

    class codepage_lookup_tracker;
        logic [15:0]    cp_list [DEPTH];
        logic [7:0]     byte_list [DEPTH];
        int             used;
        int             peak;
        lookup_result_t awaited [$];
        int             errors;
        int             checked;
        int             rejects;
        int             op_seen [4];

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                cp_list[i]   = (i < RESET_ENTRIES) ? i[15:0] : 16'd0;
                byte_list[i] = (i < RESET_ENTRIES) ? i[7:0] : 8'd0;
            end
            used = (RESET_ENTRIES < DEPTH) ? RESET_ENTRIES : DEPTH;
            peak = used;
        endfunction

        // first slot whose code is not below the given one
        function int slot_of(logic [15:0] code);
            for (int i = 0; i < used; i++) begin
                if (cp_list[i] >= code)
                    return i;
            end
            return used;
        endfunction

        function bit holds(logic [15:0] code);
            int pos;
            pos = slot_of(code);
            return (pos < used) && (cp_list[pos] == code);
        endfunction

        function logic [15:0] any_code();
            return cp_list[$urandom_range(0, used - 1)];
        endfunction

        function logic [15:0] fresh_code();
            logic [15:0] c;
            do c = 16'($urandom); while (holds(c));
            return c;
        endfunction

        function void apply_request(logic [1:0] op, logic [15:0] code, logic [7:0] mb);
            int pos;
            pos = slot_of(code);
            op_seen[op]++;
            case (op)
                OP_TRANSLATE: begin
                    if (pos < used && cp_list[pos] == code)
                        awaited.push_back('{KIND_BYTE, byte_list[pos]});
                end
                OP_LOAD: begin
                    if (pos < used && cp_list[pos] == code) begin
                        byte_list[pos] = mb;
                    end else if (used >= DEPTH) begin
                        awaited.push_back('{KIND_REJECT, 8'd0});
                        rejects++;
                    end else begin
                        for (int j = used; j > pos; j--) begin
                            cp_list[j]   = cp_list[j-1];
                            byte_list[j] = byte_list[j-1];
                        end
                        cp_list[pos]   = code;
                        byte_list[pos] = mb;
                        used++;
                        if (used > peak)
                            peak = used;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        cp_list[i]   = 16'd0;
                        byte_list[i] = 8'd0;
                    end
                    used = 1;
                end
                default: ;
            endcase
        endfunction

        function void compare_result(logic kind, logic [7:0] value);
            lookup_result_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got kind %0d byte 0x%02h",
                         $time, kind, value);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (kind !== want.kind) begin
                errors++;
                $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind);
            end
            if (value !== want.value) begin
                errors++;
                $display("%0t: byte mismatch, expected 0x%02h, got 0x%02h",
                         $time, want.value, value);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // code[15:0], mapped_byte[23:16]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tuser;   // kind[0]

    codepage_lookup_tracker tracker = new();

    int sent;
    int burst_left;
    int stall_left;
    int mode_left;
    bit calm;
    int cycle_count;

    codepoint_to_byte_table_translator #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.apply_request(s_tuser, s_tdata[15:0], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                tracker.compare_result(m_tuser, m_tdata);
        end
    end

    // receiver: calm stretches, short blips, and long stalls that hold a result
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(500, 3000);
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (!calm && $urandom_range(0, 199) == 0) begin
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 1100)
                                                     : $urandom_range(1, 40);
            m_tready   = 1'b0;
        end else begin
            m_tready = calm ? 1'b1 : ($urandom_range(0, 7) != 0);
        end
    end

    // returns at a falling edge, after any gap the burst pattern calls for
    task automatic next_slot();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(100, 700);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_request(logic [1:0] op, logic [15:0] code, logic [7:0] mb);
        s_tuser  = op;
        s_tdata  = {mb, code};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    function automatic void pick_mixed(output logic [1:0] op, output logic [15:0] code,
                                       output logic [7:0] mb);
        int roll;
        roll = $urandom_range(0, 99);
        mb   = 8'($urandom);
        code = 16'($urandom);
        if ($urandom_range(0, 15) == 0)
            code = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (roll < 45) begin
            op = OP_TRANSLATE;
            if (roll < 30)
                code = tracker.any_code();
        end else if (roll < 88) begin
            op = OP_LOAD;
            if (roll < 60)
                code = tracker.any_code();
        end else if (roll < 92) begin
            op = OP_CLEAR;
        end else begin
            op = OP_UNUSED;
        end
    endfunction

    request_t opening [25] = '{
        '{OP_TRANSLATE, 16'h0000, 8'h00},
        '{OP_TRANSLATE, 16'h007F, 8'hFF},
        '{OP_TRANSLATE, 16'h0080, 8'h00},
        '{OP_TRANSLATE, 16'hFFFF, 8'h00},
        '{OP_LOAD,      16'hFFFF, 8'hFF},
        '{OP_TRANSLATE, 16'hFFFF, 8'h00},
        '{OP_LOAD,      16'h0000, 8'hAA},
        '{OP_TRANSLATE, 16'h0000, 8'h00},
        '{OP_LOAD,      16'h8000, 8'h5A},
        '{OP_TRANSLATE, 16'h8000, 8'hFF},
        '{OP_TRANSLATE, 16'h7FFF, 8'h00},
        '{OP_UNUSED,    16'h0005, 8'h33},
        '{OP_TRANSLATE, 16'h0005, 8'h00},
        '{OP_LOAD,      16'h0005, 8'h00},
        '{OP_TRANSLATE, 16'h0005, 8'h00},
        '{OP_CLEAR,     16'h1234, 8'hC3},
        '{OP_TRANSLATE, 16'h0000, 8'h00},
        '{OP_TRANSLATE, 16'h0005, 8'h00},
        '{OP_TRANSLATE, 16'h007F, 8'h00},
        '{OP_LOAD,      16'hFFFF, 8'h81},
        '{OP_TRANSLATE, 16'hFFFF, 8'h00},
        '{OP_LOAD,      16'h0001, 8'h7E},
        '{OP_TRANSLATE, 16'h0001, 8'h00},
        '{OP_UNUSED,    16'hFFFF, 8'hFF},
        '{OP_TRANSLATE, 16'h0000, 8'h00}
    };

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("codepoint_to_byte_table_translator verification failed");
        $finish;
    end

    initial begin
        logic [1:0]  op;
        logic [15:0] code;
        logic [7:0]  mb;
        int          roll;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        sent       = 0;
        burst_left = 0;
        stall_left = 0;
        mode_left  = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        foreach (opening[i]) begin
            next_slot();
            send_request(opening[i].op, opening[i].code, opening[i].mb);
        end

        // fill the table with new codes, with some lookups mixed in
        while (tracker.used < DEPTH) begin
            next_slot();
            if ($urandom_range(0, 5) == 0)
                send_request(OP_TRANSLATE,
                             $urandom_range(0, 1) ? tracker.any_code() : 16'($urandom),
                             8'($urandom));
            else
                send_request(OP_LOAD, tracker.fresh_code(), 8'($urandom));
        end

        // full table: new codes are rejected, present codes still replaced, with lookups and unused ops mixed in
        repeat (30) begin
            next_slot();
            roll = $urandom_range(0, 10);
            mb   = 8'($urandom);
            case (roll)
                0, 1, 2, 3: send_request(OP_LOAD, tracker.fresh_code(), mb);
                4, 5:       send_request(OP_LOAD, tracker.any_code(), mb);
                6, 7, 8:    send_request(OP_TRANSLATE, tracker.any_code(), mb);
                9:          send_request(OP_TRANSLATE, tracker.cp_list[tracker.used-1], mb);
                default:    send_request(OP_UNUSED, 16'($urandom), mb);
            endcase
        end
        next_slot();
        send_request(OP_CLEAR, 16'($urandom), 8'($urandom));

        while (sent < ITEM_TARGET) begin
            next_slot();
            pick_mixed(op, code, mb);
            send_request(op, code, mb);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge aclk);
        repeat (2 * DEPTH + 8) @(posedge aclk);

        $display("covered %0d requests: %0d translate, %0d load, %0d clear, %0d unused op",
                 sent, tracker.op_seen[OP_TRANSLATE], tracker.op_seen[OP_LOAD],
                 tracker.op_seen[OP_CLEAR], tracker.op_seen[OP_UNUSED]);
        $display("%0d results compared, %0d full-table rejects, table peaked at %0d entries",
                 tracker.checked, tracker.rejects, tracker.peak);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("codepoint_to_byte_table_translator verification clean");
        else
            $display("codepoint_to_byte_table_translator verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ctbt_pkg.sv
design/ctbt_cell.sv
design/codepoint_to_byte_table_translator.sv
bench/codepoint_to_byte_table_translator_tb.sv
